// ----- sv/ovr_pkg.sv -----
// Shared types and constants for the overlay row slot allocator.
`timescale 1ns / 1ps
`default_nettype none
package ovr_pkg;

  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_LIFE_SPAN   = 3'd0;
  localparam logic [2:0] REG_ROW_MARGIN  = 3'd1;
  localparam logic [2:0] REG_SURF_TOP    = 3'd2;
  localparam logic [2:0] REG_SURF_BOTTOM = 3'd3;
  localparam logic [2:0] REG_SURF_WIDTH  = 3'd4;
  localparam logic [2:0] REG_DENSE_MODE  = 3'd5;

  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_HIT  = 2'd2;

  localparam logic [1:0] OUT_PLACED  = 2'd0;
  localparam logic [1:0] OUT_DENSE   = 2'd1;
  localparam logic [1:0] OUT_DROPPED = 2'd2;
  localparam logic [1:0] OUT_OTHER   = 2'd3;

  localparam logic [15:0] LIFE_SPAN_RESET = 16'd5000;
  localparam logic [11:0] SURF_BOTTOM_RESET = 12'd1080;
  localparam logic [11:0] SURF_WIDTH_RESET = 12'd1920;

  typedef struct packed {
    logic [11:0]        y;
    logic [11:0]        h;
    logic signed [12:0] x;
    logic [11:0]        w;
    logic signed [16:0] life;
    logic [15:0]        id;
  } ovr_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INSERT,
    ST_TICK,
    ST_HIT,
    ST_RESULT
  } ovr_state_t;

endpackage
`default_nettype wire

// ----- sv/ovr_cell.sv -----
// One table slot of the entry chain: shifts toward the head or takes a write.
`timescale 1ns / 1ps
`default_nettype none
module ovr_cell (
  input  wire logic              clk,
  input  wire logic              shift,
  input  wire logic              load,
  input  wire ovr_pkg::ovr_entry_t nb,
  input  wire ovr_pkg::ovr_entry_t wdata,
  output ovr_pkg::ovr_entry_t    q
);

  always_ff @(posedge clk) begin
    if (load) begin
      q <= wdata;
    end else if (shift) begin
      q <= nb;
    end
  end

endmodule
`default_nettype wire

// ----- sv/overlay_row_slot_allocator.sv -----
// Top level: APB registers, request sequencer and the chain of entry cells.
//
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+---------------------
//  in       | in_valid/in_ready, req_type..probe_y      | request
//  out      | out_valid/out_ready, outcome..hit_id      | one result per request
//  apb      | psel penable pwrite paddr pwdata prdata    | configuration
//
// The table is a chain of TABLE_ENTRIES cells; each pass shifts every entry once
// past the head cell, where the sequencer examines it and writes it back
// (a tick drops expired entries). Tick and hit test make one pass; an add
// that places makes two (scan, insert), a dropped add one, a full table none.
// Reset restores the registers and clears the entry count; the cells keep their
// contents. The result register holds while out_ready is low.
`timescale 1ns / 1ps
`default_nettype none
module overlay_row_slot_allocator #(
  parameter int TABLE_ENTRIES = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 req_type,
  input  wire logic [11:0]                box_height,
  input  wire logic [11:0]                box_width,
  input  wire logic [15:0]                box_id,
  input  wire logic [15:0]                elapsed,
  input  wire logic [11:0]                probe_x,
  input  wire logic [11:0]                probe_y,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      outcome,
  output logic [11:0]                     placed_y,
  output logic signed [12:0]              placed_x,
  output logic                            hit_found,
  output logic [15:0]                     hit_id,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ovr_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

  // configuration
  logic [15:0] life_span;
  logic [7:0]  row_margin;
  logic [11:0] surface_top;
  logic [11:0] surface_bottom;
  logic [11:0] surface_width;
  logic        dense_mode;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      life_span      <= ovr_pkg::LIFE_SPAN_RESET;
      row_margin     <= '0;
      surface_top    <= '0;
      surface_bottom <= ovr_pkg::SURF_BOTTOM_RESET;
      surface_width  <= ovr_pkg::SURF_WIDTH_RESET;
      dense_mode     <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        ovr_pkg::REG_LIFE_SPAN:   life_span      <= pwdata[15:0];
        ovr_pkg::REG_ROW_MARGIN:  row_margin     <= pwdata[7:0];
        ovr_pkg::REG_SURF_TOP:    surface_top    <= pwdata[11:0];
        ovr_pkg::REG_SURF_BOTTOM: surface_bottom <= pwdata[11:0];
        ovr_pkg::REG_SURF_WIDTH:  surface_width  <= pwdata[11:0];
        ovr_pkg::REG_DENSE_MODE:  dense_mode     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      ovr_pkg::REG_LIFE_SPAN:   prdata = {16'd0, life_span};
      ovr_pkg::REG_ROW_MARGIN:  prdata = {24'd0, row_margin};
      ovr_pkg::REG_SURF_TOP:    prdata = {20'd0, surface_top};
      ovr_pkg::REG_SURF_BOTTOM: prdata = {20'd0, surface_bottom};
      ovr_pkg::REG_SURF_WIDTH:  prdata = {20'd0, surface_width};
      ovr_pkg::REG_DENSE_MODE:  prdata = {31'd0, dense_mode};
      default:                  prdata = '0;
    endcase
  end

  // cell chain
  ovr_pkg::ovr_entry_t q [TABLE_ENTRIES];
  ovr_pkg::ovr_entry_t wr_data;
  logic [IW-1:0]       wr_idx;
  logic                wr_en;
  logic                pass_on;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ovr_pkg::ovr_entry_t nb;
    if (i == TABLE_ENTRIES - 1) begin : g_tail
      assign nb = '0;
    end else begin : g_mid
      assign nb = q[i+1];
    end
    ovr_cell u_cell (
      .clk   (clk),
      .shift (pass_on),
      .load  (wr_en && (wr_idx == IW'(i))),
      .nb    (nb),
      .wdata (wr_data),
      .q     (q[i])
    );
  end

  // sequencer state
  ovr_pkg::ovr_state_t state, state_next;
  logic [IW-1:0]       t, t_next;
  logic [CW-1:0]       cnt, cnt_next;
  logic [CW-1:0]       k, k_next;
  logic signed [15:0]  cur, cur_next, lastb, lastb_next, best, best_next;
  logic signed [15:0]  dsy, dsy_next;
  logic [IW-1:0]       bestpos, bestpos_next, pos, pos_next;
  logic                found, found_next, stop, stop_next;
  logic [11:0]         rh, rpx, rpy;
  logic [15:0]         rstep;
  ovr_pkg::ovr_entry_t nent, nent_next, hold, hold_next;
  logic                out_valid_next;
  logic [1:0]          r_outcome, r_outcome_next;
  logic [11:0]         r_y, r_y_next;
  logic                r_hit, r_hit_next;
  logic [15:0]         r_hid, r_hid_next;

  ovr_pkg::ovr_entry_t head;
  logic                live;
  logic signed [15:0]  ey, eh, hs, mg, bot, ins_y;
  logic signed [15:0]  gap, lb_new, cur_new;
  logic signed [17:0]  life_new;
  logic signed [13:0]  hx, hxw, pxs;
  logic signed [15:0]  hyh, pys;
  logic signed [12:0]  cx;
  logic                accept;

  assign head   = q[0];
  assign live   = CW'(t) < cnt;
  assign ey     = $signed({4'd0, head.y});
  assign eh     = $signed({4'd0, head.h});
  assign hs     = $signed({4'd0, rh});
  assign mg     = $signed({8'd0, row_margin});
  assign bot    = $signed({4'd0, surface_bottom});
  assign gap    = ey - lastb;
  assign lb_new = ey + mg;
  assign cur_new = lb_new + eh;
  assign life_new = $signed({head.life[16], head.life}) - $signed({2'd0, rstep});
  assign hx     = $signed({head.x[12], head.x});
  assign hxw    = hx + $signed({2'd0, head.w});
  assign pxs    = $signed({2'd0, rpx});
  assign pys    = $signed({4'd0, rpy});
  assign hyh    = ey + eh;
  // floor of half by arithmetic shift
  assign cx     = 13'(($signed({1'b0, surface_width}) - $signed({1'b0, box_width})) >>> 1);
  assign ins_y  = found ? cur : dsy;
  assign accept = in_valid && in_ready;
  assign in_ready = (state == ovr_pkg::ST_IDLE);

  always_comb begin
    state_next     = state;
    t_next         = t;
    cnt_next       = cnt;
    k_next         = k;
    cur_next       = cur;
    lastb_next     = lastb;
    best_next      = best;
    dsy_next       = dsy;
    bestpos_next   = bestpos;
    pos_next       = pos;
    found_next     = found;
    stop_next      = stop;
    nent_next      = nent;
    hold_next      = hold;
    out_valid_next = out_valid && !out_ready;
    r_outcome_next = r_outcome;
    r_y_next       = r_y;
    r_hit_next     = r_hit;
    r_hid_next     = r_hid;
    pass_on        = 1'b0;
    wr_en          = 1'b0;
    wr_idx         = LAST;
    wr_data        = head;

    case (state)
      ovr_pkg::ST_IDLE: begin
        if (accept) begin
          t_next       = '0;
          k_next       = '0;
          found_next   = 1'b0;
          stop_next    = 1'b0;
          cur_next     = $signed({8'd0, row_margin}) + $signed({4'd0, surface_top});
          lastb_next   = $signed({4'd0, surface_top});
          best_next    = '0;
          dsy_next     = '0;
          bestpos_next = '0;
          nent_next    = '{y: '0, h: box_height, x: cx, w: box_width,
                          life: $signed({1'b0, life_span}), id: box_id};
          r_outcome_next = ovr_pkg::OUT_OTHER;
          r_y_next     = '0;
          r_hit_next   = 1'b0;
          r_hid_next   = '0;
          case (req_type)
            ovr_pkg::REQ_ADD: begin
              r_outcome_next = ovr_pkg::OUT_PLACED;
              if (cnt >= CW'(TABLE_ENTRIES)) begin
                r_outcome_next = ovr_pkg::OUT_DROPPED;
                state_next = ovr_pkg::ST_RESULT;
              end else begin
                state_next = ovr_pkg::ST_SCAN;
              end
            end
            ovr_pkg::REQ_TICK: state_next = ovr_pkg::ST_TICK;
            ovr_pkg::REQ_HIT:  state_next = ovr_pkg::ST_HIT;
            default:           state_next = ovr_pkg::ST_RESULT;
          endcase
        end
      end

      ovr_pkg::ST_SCAN: begin
        pass_on = 1'b1;
        wr_en   = 1'b1;
        if (live && !found && !stop) begin
          if (ey - cur - mg >= hs) begin
            found_next = 1'b1;
            pos_next   = t;
          end else begin
            if (gap > best) begin
              best_next    = gap;
              dsy_next     = lastb + (gap >>> 1);
              bestpos_next = t;
            end
            lastb_next = lb_new;
            cur_next   = cur_new;
            if (cur_new + hs >= bot) stop_next = 1'b1;
          end
        end
        t_next = t + 1'b1;
        if (t == LAST) begin
          t_next = '0;
          state_next = ovr_pkg::ST_INSERT;
          if (found_next) begin
            r_outcome_next = ovr_pkg::OUT_PLACED;
          end else if (cur_next + hs < bot) begin
            found_next     = 1'b1;
            pos_next       = cnt[IW-1:0];
            r_outcome_next = ovr_pkg::OUT_PLACED;
          end else if (dense_mode) begin
            pos_next       = bestpos_next;
            r_outcome_next = ovr_pkg::OUT_DENSE;
          end else begin
            r_outcome_next = ovr_pkg::OUT_DROPPED;
            state_next     = ovr_pkg::ST_RESULT;
          end
        end
      end

      ovr_pkg::ST_INSERT: begin
        pass_on = 1'b1;
        wr_en   = 1'b1;
        if (t == pos) begin
          wr_data   = nent;
          wr_data.y = ins_y[11:0];
          hold_next = head;
        end else if (t > pos) begin
          wr_data   = hold;
          hold_next = head;
        end
        t_next = t + 1'b1;
        if (t == LAST) begin
          t_next     = '0;
          cnt_next   = cnt + 1'b1;
          r_y_next   = ins_y[11:0];
          state_next = ovr_pkg::ST_RESULT;
        end
      end

      ovr_pkg::ST_TICK: begin
        pass_on = 1'b1;
        if (live && (life_new > 18'sd0)) begin
          wr_en        = 1'b1;
          wr_idx       = IW'(k + CW'(LAST) - CW'(t));
          wr_data.life = life_new[16:0];
          k_next       = k + 1'b1;
        end
        t_next = t + 1'b1;
        if (t == LAST) begin
          t_next     = '0;
          cnt_next   = k_next;
          state_next = ovr_pkg::ST_RESULT;
        end
      end

      ovr_pkg::ST_HIT: begin
        pass_on = 1'b1;
        wr_en   = 1'b1;
        if (live && !r_hit && (hx < pxs) && (hxw > pxs) && (ey < pys) && (hyh > pys)) begin
          r_hit_next = 1'b1;
          r_hid_next = head.id;
        end
        t_next = t + 1'b1;
        if (t == LAST) begin
          t_next     = '0;
          state_next = ovr_pkg::ST_RESULT;
        end
      end

      ovr_pkg::ST_RESULT: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          state_next     = ovr_pkg::ST_IDLE;
        end
      end

      default: state_next = ovr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ovr_pkg::ST_IDLE;
      cnt       <= '0;
      t         <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      t         <= t_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    k         <= k_next;
    cur       <= cur_next;
    lastb     <= lastb_next;
    best      <= best_next;
    dsy       <= dsy_next;
    bestpos   <= bestpos_next;
    pos       <= pos_next;
    found     <= found_next;
    stop      <= stop_next;
    nent      <= nent_next;
    hold      <= hold_next;
    r_outcome <= r_outcome_next;
    r_y       <= r_y_next;
    r_hit     <= r_hit_next;
    r_hid     <= r_hid_next;
    if (accept) begin
      rh    <= box_height;
      rstep <= elapsed;
      rpx   <= probe_x;
      rpy   <= probe_y;
    end
    if (state == ovr_pkg::ST_RESULT && (!out_valid || out_ready)) begin
      outcome   <= r_outcome;
      hit_found <= r_hit;
      hit_id    <= r_hid;
      if (r_outcome inside {ovr_pkg::OUT_PLACED, ovr_pkg::OUT_DENSE}) begin
        placed_y <= r_y;
        placed_x <= nent.x;
      end else begin
        placed_y <= '0;
        placed_x <= '0;
      end
    end
  end

endmodule
`default_nettype wire
